### src/bbr_pkg.sv
// ============================================================================
// Box blur package
// Shared constants, payload types and arithmetic helpers for the 3x3 RGB
// box blur block.
// ============================================================================
package bbr_pkg;

   // Frame geometry limits.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Configuration register width and derived counter widths.
   localparam int CFG_W     = 12;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WCNT_W    = COL_W + 1;
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int HCNT_W    = ROW_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W     = 12;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Register reset values, before clamping.
   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   // Input word commands.
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Reciprocal of 9 scaled by 2^16; exact floor for sums up to 2295.
   localparam logic [12:0] DIV9_RECIP = 13'd7282;

   typedef struct packed {
      logic       command;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Source of the pixel that a word delivers.
   typedef enum logic [1:0] {
      SEL_HOLD   = 2'd0,
      SEL_BLUR   = 2'd1,
      SEL_UPPER  = 2'd2,
      SEL_MIDDLE = 2'd3
   } sel_type;

   // One accepted word as it travels from the control to the datapath.
   typedef struct packed {
      logic             write_line;
      logic             emit;
      logic             last;
      sel_type          sel;
      logic [COL_W-1:0] addr;
      pixel_type        pix;
   } item_type;

   // Effective line width: zero counts as one, large values saturate.
   function automatic logic [WCNT_W-1:0] clamp_width(input logic [CFG_W-1:0] raw);
      logic [WCNT_W-1:0] w;
      if (raw == '0) begin
         w = WCNT_W'(1);
      end else if (int'(raw) > MAX_WIDTH) begin
         w = WCNT_W'(MAX_WIDTH);
      end else begin
         w = WCNT_W'(raw);
      end
      return w;
   endfunction

   // Effective frame height: zero counts as one, large values saturate.
   function automatic logic [HCNT_W-1:0] clamp_height(input logic [CFG_W-1:0] raw);
      logic [HCNT_W-1:0] h;
      if (raw == '0) begin
         h = HCNT_W'(1);
      end else if (int'(raw) > MAX_HEIGHT) begin
         h = HCNT_W'(MAX_HEIGHT);
      end else begin
         h = HCNT_W'(raw);
      end
      return h;
   endfunction

   // Floor of a nine-term channel sum divided by nine.
   function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
      logic [24:0] prod;
      prod = 25'(sum) * 25'(DIV9_RECIP);
      return prod[23:16];
   endfunction

endpackage

### src/bbr_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module bbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bbr_ctrl.sv
// ============================================================================
// Box blur control
// Holds the frame geometry, tracks input and output raster positions, decides
// what each accepted word produces and registers it for the datapath.
// ============================================================================
module bbr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [bbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbr_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_accept,
   input  bbr_pkg::req_type              req_data,
   input  logic                          s1_advance,
   output logic                          s1_valid,
   output bbr_pkg::item_type             s1_item,
   output logic [bbr_pkg::COL_W-1:0]     rd_addr
);

   import bbr_pkg::*;

   logic [WCNT_W-1:0] width_ff, width_in;
   logic [HCNT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [HCNT_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff, s1_item_in;

   logic     in_frame;
   logic     col_zero;
   logic     col_last;
   logic     out_col_last;
   logic     out_row_last;
   logic     is_flush;
   logic     pixel_ok;
   logic     flush_ok;
   logic     emit_prev;
   logic     emit_cur;
   logic     restart;
   item_type item_in;

   // Decode the incoming word against the current raster position.
   always_comb begin
      in_frame     = row_ff < height_ff;
      col_zero     = col_ff == '0;
      col_last     = (WCNT_W'(col_ff) + WCNT_W'(1)) == width_ff;
      out_col_last = (WCNT_W'(out_col_ff) + WCNT_W'(1)) == width_ff;
      out_row_last = (HCNT_W'(out_row_ff) + HCNT_W'(1)) == height_ff;
      is_flush     = req_data.command == CMD_FLUSH;
      pixel_ok     = !is_flush && in_frame;
      flush_ok     = is_flush && !in_frame;
      // The last pixel of the row two above leaves when a new row starts.
      emit_prev    = pixel_ok && col_zero && (row_ff >= HCNT_W'(2));
      emit_cur     = pixel_ok && !col_zero && (row_ff != '0);

      item_in.write_line = pixel_ok;
      item_in.emit       = emit_prev || emit_cur || flush_ok;
      item_in.last       = flush_ok && out_row_last && out_col_last;
      if (flush_ok) begin
         item_in.sel = out_row_last ? SEL_MIDDLE : SEL_UPPER;
      end else if (emit_cur && (row_ff >= HCNT_W'(2)) && (col_ff >= COL_W'(2))) begin
         item_in.sel = SEL_BLUR;
      end else begin
         item_in.sel = SEL_HOLD;
      end
      item_in.addr      = flush_ok ? out_col_ff : col_ff;
      item_in.pix.red   = req_data.red_in;
      item_in.pix.green = req_data.green_in;
      item_in.pix.blue  = req_data.blue_in;
   end

   assign rd_addr = item_in.addr;

   // Geometry registers and raster position counters.
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      restart    = 1'b0;

      if (csr_wen) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = clamp_width(csr_wdata);
               restart  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = clamp_height(csr_wdata);
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end else if (req_accept) begin
         if (item_in.last) begin
            restart = 1'b1;
         end else begin
            if (pixel_ok) begin
               if (col_last) begin
                  col_in = '0;
                  row_in = row_ff + HCNT_W'(1);
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
            if (item_in.emit) begin
               if (out_col_last) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end

      if (restart) begin
         col_in     = '0;
         row_in     = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // Stage register toward the datapath.
   always_comb begin
      s1_item_in = s1_item_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_item_in  = item_in;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= clamp_width(WIDTH_RESET);
         height_ff   <= clamp_height(HEIGHT_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

endmodule

### src/bbr_datapath.sv
// ============================================================================
// Box blur datapath
// Shifts the 3x3 window, forms the blurred pixel, picks the delivered pixel
// and writes the line stores back.
// ============================================================================
module bbr_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s1_advance,
   input  bbr_pkg::item_type         s1_item,
   input  bbr_pkg::pixel_type        upper_rdata,
   input  bbr_pkg::pixel_type        middle_rdata,
   output logic                      line_wen,
   output logic [bbr_pkg::COL_W-1:0] line_waddr,
   output bbr_pkg::pixel_type        upper_wdata,
   output bbr_pkg::pixel_type        middle_wdata,
   output bbr_pkg::rsp_type          result
);

   import bbr_pkg::*;

   // Window columns: col1 is older, col2 is the most recent; index 0 is the top row.
   pixel_type col1_ff [3];
   pixel_type col1_in [3];
   pixel_type col2_ff [3];
   pixel_type col2_in [3];

   // Last line store write, to cover a read issued at the same edge.
   logic             fwd_valid_ff, fwd_valid_in;
   logic [COL_W-1:0] fwd_addr_ff, fwd_addr_in;
   pixel_type        fwd_upper_ff, fwd_upper_in;
   pixel_type        fwd_middle_ff, fwd_middle_in;

   logic             fwd_hit;
   pixel_type        up_col;
   pixel_type        mid_col;
   pixel_type        new_col [3];
   logic [SUM_W-1:0] red_sum;
   logic [SUM_W-1:0] green_sum;
   logic [SUM_W-1:0] blue_sum;
   pixel_type        blur_pix;
   pixel_type        res_pix;

   // Line store data, with the pending write forwarded.
   always_comb begin
      fwd_hit    = fwd_valid_ff && (fwd_addr_ff == s1_item.addr);
      up_col     = fwd_hit ? fwd_upper_ff : upper_rdata;
      mid_col    = fwd_hit ? fwd_middle_ff : middle_rdata;
      new_col[0] = up_col;
      new_col[1] = mid_col;
      new_col[2] = s1_item.pix;
   end

   // Nine-term channel sums over the shifted window, then divide by nine.
   always_comb begin
      red_sum   = '0;
      green_sum = '0;
      blue_sum  = '0;
      for (int i = 0; i < 3; i++) begin
         red_sum   = red_sum + SUM_W'(col1_ff[i].red) + SUM_W'(col2_ff[i].red)
                     + SUM_W'(new_col[i].red);
         green_sum = green_sum + SUM_W'(col1_ff[i].green) + SUM_W'(col2_ff[i].green)
                     + SUM_W'(new_col[i].green);
         blue_sum  = blue_sum + SUM_W'(col1_ff[i].blue) + SUM_W'(col2_ff[i].blue)
                     + SUM_W'(new_col[i].blue);
      end
      blur_pix.red   = div9(red_sum);
      blur_pix.green = div9(green_sum);
      blur_pix.blue  = div9(blue_sum);
   end

   // Pick the delivered pixel. The held pixel is the window center after the shift.
   always_comb begin
      case (s1_item.sel)
         SEL_HOLD:   res_pix = col2_ff[1];
         SEL_BLUR:   res_pix = blur_pix;
         SEL_UPPER:  res_pix = up_col;
         SEL_MIDDLE: res_pix = mid_col;
         default:    res_pix = col2_ff[1];
      endcase
      result.red_out   = res_pix.red;
      result.green_out = res_pix.green;
      result.blue_out  = res_pix.blue;
      result.frame_end = s1_item.last;
   end

   // Line store write-back: the middle row moves up, the new pixel becomes the middle.
   assign line_wen     = s1_advance && s1_item.write_line;
   assign line_waddr   = s1_item.addr;
   assign upper_wdata  = mid_col;
   assign middle_wdata = s1_item.pix;

   // Window shift and forwarding registers.
   always_comb begin
      col1_in       = col1_ff;
      col2_in       = col2_ff;
      fwd_valid_in  = fwd_valid_ff;
      fwd_addr_in   = fwd_addr_ff;
      fwd_upper_in  = fwd_upper_ff;
      fwd_middle_in = fwd_middle_ff;
      if (line_wen) begin
         col1_in       = col2_ff;
         col2_in       = new_col;
         fwd_valid_in  = 1'b1;
         fwd_addr_in   = line_waddr;
         fwd_upper_in  = upper_wdata;
         fwd_middle_in = middle_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col1_ff       <= col1_in;
      col2_ff       <= col2_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_upper_ff  <= fwd_upper_in;
      fwd_middle_ff <= fwd_middle_in;
   end

endmodule

### src/box_blur_3x3_rgb.sv
// ============================================================================
// 3x3 RGB box blur
// Streaming box filter with two line stores and a registered result word.
// ============================================================================
// Usage:
// Pixels enter on the req_ channel in raster order, one word each (command
// pixel). Each interior pixel leaves as the per-channel floor of its 3x3
// neighborhood sum divided by nine; first and last rows and columns pass
// through unchanged. A result trails its input position by one line plus one
// pixel, so after the last pixel of a frame the sender issues flush words to
// drain the remaining line plus one (the whole line of a one-line frame);
// rsp_data.frame_end marks the final pixel.
// Frame size is set through csr_ (index 0 width, 1 height) while idle; a
// write restarts the frame.
// A word that causes a result is registered in the window stage and then in the
// result register, which drives rsp_valid and rsp_data.
// Throughput: one word per cycle unless the receiver stalls a held result, with a
// registered read of the two line store memories.
// Reset gives 640x480 and an empty pipeline; line store contents are kept.
// When the receiver stalls, one word waits in the result register; req_ready
// drops once the word in the window stage also has a result to deliver, and
// rises again with rsp_ready.
// ============================================================================
module box_blur_3x3_rgb (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bbr_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bbr_pkg::rsp_type              rsp_data,
   input  logic                          csr_wen,
   input  logic [bbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbr_pkg::CFG_W-1:0]     csr_wdata
);

   import bbr_pkg::*;

   logic             req_accept;
   logic             s1_valid;
   item_type         s1_item;
   logic             s1_advance;
   logic             out_free;
   logic [COL_W-1:0] rd_addr;
   pixel_type        upper_rdata;
   pixel_type        middle_rdata;
   logic             line_wen;
   logic [COL_W-1:0] line_waddr;
   pixel_type        upper_wdata;
   pixel_type        middle_wdata;
   rsp_type          result;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Handshake: the window stage moves on when its word needs no slot or one is free.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid && (!s1_item.emit || out_free);
   assign req_ready  = !s1_valid || s1_advance;
   assign req_accept = req_valid && req_ready;

   bbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_data   (req_data),
      .s1_advance (s1_advance),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .rd_addr    (rd_addr)
   );

   // Line store holding the row two above the incoming row.
   bbr_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (line_wen),
      .wr_addr (line_waddr),
      .wr_data (upper_wdata),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (upper_rdata)
   );

   // Line store holding the row one above the incoming row.
   bbr_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (line_wen),
      .wr_addr (line_waddr),
      .wr_data (middle_wdata),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (middle_rdata)
   );

   bbr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .s1_advance   (s1_advance),
      .s1_item      (s1_item),
      .upper_rdata  (upper_rdata),
      .middle_rdata (middle_rdata),
      .line_wen     (line_wen),
      .line_waddr   (line_waddr),
      .upper_wdata  (upper_wdata),
      .middle_wdata (middle_wdata),
      .result       (result)
   );

   // Result register.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s1_advance && s1_item.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/bbr_checker.sv
// ============================================================================
// Box blur port checker
// Watches the top-level ports for handshake and timing rules of the block.
// ============================================================================
module bbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bbr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bbr_pkg::rsp_type rsp_data
);

   import bbr_pkg::*;

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // With a free result slot the input side never stalls.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while the result slot was free");

   // A result word that appears in an empty slot comes from an earlier accepted input word.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without an accepted input word");

   // The end of a frame is only ever delivered in answer to a flush word.
   a_frame_end_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_data.frame_end |-> $past(req_data.command, 2) == CMD_FLUSH)
      else $error("frame end not caused by a flush word");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);

### verif/tb_box_blur_3x3_rgb.sv
// ============================================================================
// 3x3 RGB box blur testbench
// Sends pixel and flush words through the request channel and checks every
// result word against a value typed in the table or an in-bench copy of the line stores and the 3x3 window.
// A short table covers the corner cases, then short partial frames at the
// largest and saturated sizes, then random frames of small sizes under four
// idling patterns.
// ============================================================================
module tb_box_blur_3x3_rgb;
   import bbr_pkg::*;

   localparam int RANDOM_ITEMS  = 1600;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 500000;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_type;
   typedef enum logic [1:0] {ROW_WORD, ROW_FRAME} row_kind_type;
   typedef enum logic [1:0] {EXP_NONE, EXP_TYPED, EXP_PREDICT} exp_kind_type;

   // One row of the directed table: either a frame size or a single word.
   typedef struct packed {
      row_kind_type     kind;
      logic [CFG_W-1:0] wd;
      logic [CFG_W-1:0] ht;
      req_type          word;
      exp_kind_type     how;
      rsp_type          want;
   } plan_row_type;

   localparam int PLAN_ROWS = 21;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]     csr_wdata = '0;

   idle_type    idle_mode = IDLE_NONE;
   rsp_type     blurred_q[$];
   int unsigned mismatches = 0;
   int unsigned sent_items = 0;
   int unsigned frames_run = 0;

   // Expected state of the block: line stores, window, position, settings.
   pixel_type        upper_line [MAX_WIDTH];
   pixel_type        middle_line [MAX_WIDTH];
   pixel_type        win [3][3];
   int unsigned      next_col;
   int unsigned      next_row;
   int unsigned      pixels_out;
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;

   // Corner cases: reset size, zero sizes, the smallest frame with an interior
   // pixel, an early flush, a pixel while draining and a flush with nothing left.
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'h12, 8'h34, 8'h56}, EXP_NONE,  '0},
      '{ROW_FRAME, 12'd0, 12'd0, '0,                               EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'hff, 8'h00, 8'h80}, EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'h0},               EXP_TYPED,
        {8'hff, 8'h00, 8'h80, 1'b1}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'h0},               EXP_NONE,  '0},
      '{ROW_FRAME, 12'd3, 12'd3, '0,                               EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'hff, 8'hff, 8'hff}, EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'h00, 8'h00, 8'h00}, EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'h80, 8'h7f, 8'h01}, EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'hffffff},          EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'hff, 8'hff, 8'hff}, EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'h00, 8'h00, 8'h00}, EXP_TYPED,
        {8'hff, 8'hff, 8'hff, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'hff, 8'h00, 8'hff}, EXP_TYPED,
        {8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'hff, 8'hff, 8'hff}, EXP_TYPED,
        {8'h80, 8'h7f, 8'h01, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'h01, 8'h80, 8'hfe}, EXP_TYPED,
        {8'hff, 8'hff, 8'hff, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'hff, 8'hff, 8'hff}, EXP_PREDICT, '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_PIXEL, 8'h00, 8'hff, 8'h00}, EXP_NONE,  '0},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'h0},               EXP_TYPED,
        {8'hff, 8'h00, 8'hff, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'h0},               EXP_TYPED,
        {8'hff, 8'hff, 8'hff, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'h0},               EXP_TYPED,
        {8'h01, 8'h80, 8'hfe, 1'b0}},
      '{ROW_WORD,  12'd0, 12'd0, {CMD_FLUSH, 24'h0},               EXP_TYPED,
        {8'hff, 8'hff, 8'hff, 1'b1}}
   };

   box_blur_3x3_rgb i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Effective frame size: zero counts as one, oversized values saturate.
   function automatic int unsigned line_len();
      if (width_reg == '0) return 1;
      if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int unsigned frame_lines();
      if (height_reg == '0) return 1;
      if (int'(height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   function automatic void rewind_frame();
      next_col   = 0;
      next_row   = 0;
      pixels_out = 0;
   endfunction

   function automatic rsp_type as_word(input pixel_type p, input logic last);
      return {p, last};
   endfunction

   // Floor of the nine-pixel sum over nine, channel by channel.
   function automatic pixel_type box_average();
      int unsigned sr = 0;
      int unsigned sg = 0;
      int unsigned sb = 0;
      pixel_type   p;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sr += win[i][j].red;
            sg += win[i][j].green;
            sb += win[i][j].blue;
         end
      end
      p.red   = 8'(sr / 9);
      p.green = 8'(sg / 9);
      p.blue  = 8'(sb / 9);
      return p;
   endfunction

   // Advances the expected state by one accepted word and returns the result
   // word that it releases, if any.
   task automatic blur_predict(input req_type word, output bit got, output rsp_type r);
      int unsigned wd, ht, total, orow, ocol, idx;
      pixel_type   src;
      bit          inner;
      wd    = line_len();
      ht    = frame_lines();
      total = wd * ht;
      got   = 1'b0;
      r     = '0;
      if (word.command == CMD_FLUSH) begin
         // Drain only once the whole frame is in; the last row sits in the
         // middle store, the row above it in the upper store.
         if (next_row >= ht && pixels_out < total) begin
            orow = pixels_out / wd;
            ocol = pixels_out % wd;
            src  = (orow + 1 >= ht) ? middle_line[ocol] : upper_line[ocol];
            pixels_out++;
            r   = as_word(src, pixels_out == total);
            got = 1'b1;
            if (pixels_out == total) rewind_frame();
         end
      end else if (next_row < ht && next_col < wd) begin
         src = '{red: word.red_in, green: word.green_in, blue: word.blue_in};
         idx = next_row * wd + next_col;
         // The last pixel of the row two above leaves before the window shifts.
         if (next_col == 0 && idx >= wd + 1) begin
            r   = as_word(win[1][2], 1'b0);
            got = 1'b1;
            pixels_out++;
         end
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = upper_line[next_col];
         win[1][2] = middle_line[next_col];
         win[2][2] = src;
         upper_line[next_col]  = middle_line[next_col];
         middle_line[next_col] = src;
         if (next_col >= 1 && idx >= wd + 1) begin
            orow  = next_row - 1;
            ocol  = next_col - 1;
            inner = orow >= 1 && orow + 2 <= ht && ocol >= 1 && ocol + 2 <= wd;
            r     = as_word(inner ? box_average() : win[1][1], 1'b0);
            got   = 1'b1;
            pixels_out++;
         end
         next_col++;
         if (next_col >= wd) begin
            next_col = 0;
            next_row++;
         end
      end
   endtask

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 61;
         IDLE_BOTH:   return $urandom_range(99) < 12;
         default:     return 1'b0;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input rsp_type want, input rsp_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display({"mismatch, %s: expected r=%02h g=%02h b=%02h end=%b, ",
                   "got r=%02h g=%02h b=%02h end=%b"},
                  what, want.red_out, want.green_out, want.blue_out, want.frame_end,
                  seen.red_out, seen.green_out, seen.blue_out, seen.frame_end);
      end
   endtask

   // Offers one word, holds it until accepted, then records what it releases.
   task automatic push_word(input req_type word, input exp_kind_type how,
                            input rsp_type typed);
      bit      got;
      rsp_type predicted;
      if (sender_idles()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (sender_idles());
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      blur_predict(word, got, predicted);
      if (how == EXP_TYPED) begin
         blurred_q.push_back(typed);
      end else if (how == EXP_PREDICT && got) begin
         blurred_q.push_back(predicted);
      end
   endtask

   // Holds the sender until every expected word is out and the pipe is quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both size registers; each write restarts the frame.
   task automatic set_frame(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] ht);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= wd;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= ht;
      @(posedge clock);
      csr_wen    <= 1'b0;
      width_reg  = wd;
      height_reg = ht;
      rewind_frame();
   endtask

   // Sends one frame of random pixels and drains it, with a few stray words
   // that the block must ignore. A nonzero cut_at stops after that many pixels.
   task automatic run_frame(input int unsigned cut_at);
      int unsigned npix, n;
      bit          cut;
      req_type     word;
      npix = line_len() * frame_lines();
      cut  = cut_at != 0 && cut_at < npix;
      if (cut) npix = cut_at;
      for (n = 0; n < npix; n++) begin
         if ($urandom_range(99) < 4) begin
            word = {CMD_FLUSH, 24'($urandom)};
            push_word(word, EXP_PREDICT, '0);
         end
         if ((n == npix / 2 && frames_run % 8 == 3) || $urandom_range(199) == 0) begin
            wait_idle();
         end
         word = {CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255))};
         push_word(word, EXP_PREDICT, '0);
         sent_items++;
      end
      while (!cut && next_row != 0) begin
         if ($urandom_range(99) < 4) begin
            word = {CMD_PIXEL, 24'($urandom)};
            push_word(word, EXP_PREDICT, '0);
         end
         word = {CMD_FLUSH, 24'($urandom)};
         push_word(word, EXP_PREDICT, '0);
         sent_items++;
      end
      frames_run++;
   endtask

   // Receiver stalls according to the current idling pattern.
   always @(posedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 61);
         IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 12);
         default:       rsp_ready <= 1'b1;
      endcase
   end

   // Each accepted result word is matched against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blurred_q.size() == 0) begin
            flag_mismatch("no word expected", '0, rsp_data);
         end else begin
            want = blurred_q.pop_front();
            if (rsp_data.red_out !== want.red_out || rsp_data.green_out !== want.green_out ||
                rsp_data.blue_out !== want.blue_out || rsp_data.frame_end !== want.frame_end) begin
               flag_mismatch("word differs", want, rsp_data);
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      bit reconfig;
      foreach (upper_line[c]) begin
         upper_line[c]  = '0;
         middle_line[c] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      rewind_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (plan[n]) begin
         if (plan[n].kind == ROW_FRAME) begin
            set_frame(plan[n].wd, plan[n].ht);
         end else begin
            push_word(plan[n].word, plan[n].how, plan[n].want);
         end
      end

      // Partial frames at a saturated width, at the largest size and at a
      // saturated height.
      idle_mode = IDLE_RECEIVER;
      set_frame(12'hfff, 12'd1);
      run_frame(200);
      set_frame(12'd2048, 12'd2048);
      run_frame(30);
      set_frame(12'd0, 12'hfff);
      run_frame(40);

      // Random frames, mostly small, some cut short by a new frame size.
      reconfig = 1'b1;
      while (sent_items < RANDOM_ITEMS) begin
         idle_mode = idle_type'((frames_run / 6) % 4);
         if (reconfig || $urandom_range(99) < 60) begin
            case ($urandom_range(19))
               0:       set_frame(12'd0, 12'($urandom_range(6, 1)));
               1:       set_frame(12'($urandom_range(12, 1)), 12'd0);
               2, 3:    set_frame(12'($urandom_range(40, 13)), 12'($urandom_range(6, 1)));
               default: set_frame(12'($urandom_range(12, 1)), 12'($urandom_range(6, 1)));
            endcase
         end
         reconfig = $urandom_range(99) < 10;
         run_frame(reconfig ? $urandom_range(60, 1) : 0);
      end

      idle_mode = IDLE_NONE;
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && blurred_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
